>>> src/lever_stopwatch_display_control_macros.svh
// Assertion macros used by the checker module
`ifndef LEVER_STOPWATCH_DISPLAY_CONTROL_MACROS_SVH
`define LEVER_STOPWATCH_DISPLAY_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LSDC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lsdc same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LSDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lsdc next-cycle check failed");

`endif

>>> src/lsdc_pkg.sv
// Types and constants of the lever stopwatch display controller
package lsdc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int SINCE_W   = 17;
	localparam int MS_W      = 10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TOTAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEADY = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] START_DELAY_RST = 16'd1000;
	localparam logic [CFG_W-1:0] HOLD_TOTAL_RST  = 16'd5000;
	localparam logic [CFG_W-1:0] HOLD_STEADY_RST = 16'd3000;

	localparam logic [MS_W-1:0] MS_LAST = 10'd999;
	localparam logic [3:0] BCD_NINE = 4'd9;
	localparam logic [3:0] BCD_FIVE = 4'd5;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_START = 2'd1,
		MODE_RUN   = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	// Elapsed time in BCD, with saturation flag for 100 hours and more
	typedef struct packed {
		logic       over;
		logic [3:0] hr_t;
		logic [3:0] hr_o;
		logic [3:0] mn_t;
		logic [3:0] mn_o;
		logic [3:0] sc_t;
		logic [3:0] sc_o;
	} time_bcd_t;

	// Control from the mode logic to the elapsed counter
	typedef struct packed {
		logic load_one;
		logic advance;
	} elapsed_ctrl_t;

	typedef struct packed {
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
		logic       colon;
		logic       blank;
	} display_t;

endpackage

>>> src/lsdc_if.sv
// Valid/ready channels for ticks and display contents
interface lsdc_tick_if;
	logic valid;
	logic ready;
	logic lever_down;

	modport source (output valid, output lever_down, input ready);
	modport sink (input valid, input lever_down, output ready);
endinterface

interface lsdc_disp_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_thousands;
	logic [3:0] digit_hundreds;
	logic [3:0] digit_tens;
	logic [3:0] digit_ones;
	logic       colon_on;
	logic       blank_display;

	modport source (output valid, output digit_thousands, output digit_hundreds,
		output digit_tens, output digit_ones, output colon_on, output blank_display,
		input ready);
	modport sink (input valid, input digit_thousands, input digit_hundreds,
		input digit_tens, input digit_ones, input colon_on, input blank_display,
		output ready);
endinterface

>>> src/lsdc_half_phase.sv
// Tracks (now / HALF_MS) & 1 by counting ticks, restarting when now wraps
module lsdc_half_phase #(
	parameter int HALF_MS = 200
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic wrap,
	output logic phase
);
	localparam int REM_W = $clog2(HALF_MS + 1);
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(HALF_MS - 1);

	logic [REM_W-1:0] rem_q;
	logic             phase_q;

	// Advance the remainder, toggle the phase at each period boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			phase_q <= 1'b0;
		end else if (step) begin
			if (wrap) begin
				rem_q   <= '0;
				phase_q <= 1'b0;
			end else if (rem_q == REM_LAST) begin
				rem_q   <= '0;
				phase_q <= ~phase_q;
			end else begin
				rem_q <= rem_q + 1'b1;
			end
		end
	end

	assign phase = phase_q;

endmodule

>>> src/lsdc_elapsed.sv
// Elapsed-time counter kept directly as BCD hours, minutes and seconds
module lsdc_elapsed #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lsdc_pkg::elapsed_ctrl_t ctrl,
	output lsdc_pkg::time_bcd_t    value
);
	logic [TIME_BITS-1:0]    e_q;
	logic [lsdc_pkg::MS_W-1:0] ms_q;
	lsdc_pkg::time_bcd_t     t_q;

	logic c_sec, c_sc_t, c_min, c_mn_t, c_hr, c_hr_t, c_over;

	// Carry chain through the BCD digits
	always_comb begin
		c_sec  = (ms_q == lsdc_pkg::MS_LAST);
		c_sc_t = c_sec && (t_q.sc_o == lsdc_pkg::BCD_NINE);
		c_min  = c_sc_t && (t_q.sc_t == lsdc_pkg::BCD_FIVE);
		c_mn_t = c_min && (t_q.mn_o == lsdc_pkg::BCD_NINE);
		c_hr   = c_mn_t && (t_q.mn_t == lsdc_pkg::BCD_FIVE);
		c_hr_t = c_hr && (t_q.hr_o == lsdc_pkg::BCD_NINE);
		c_over = c_hr_t && (t_q.hr_t == lsdc_pkg::BCD_NINE);
	end

	// Load one millisecond at run start, count while running, clear on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q  <= '0;
			ms_q <= '0;
			t_q  <= '0;
		end else if (ctrl.load_one) begin
			e_q  <= TIME_BITS'(1);
			ms_q <= lsdc_pkg::MS_W'(1);
			t_q  <= '0;
		end else if (ctrl.advance) begin
			e_q <= e_q + 1'b1;
			if (&e_q) begin
				ms_q <= '0;
				t_q  <= '0;
			end else begin
				ms_q <= c_sec ? '0 : ms_q + 1'b1;
				if (c_sec)
					t_q.sc_o <= c_sc_t ? 4'd0 : t_q.sc_o + 4'd1;
				if (c_sc_t)
					t_q.sc_t <= c_min ? 4'd0 : t_q.sc_t + 4'd1;
				if (c_min)
					t_q.mn_o <= c_mn_t ? 4'd0 : t_q.mn_o + 4'd1;
				if (c_mn_t)
					t_q.mn_t <= c_hr ? 4'd0 : t_q.mn_t + 4'd1;
				// Hours stop once the count passes 99
				if (c_hr && !t_q.over) begin
					if (c_over) begin
						t_q.over <= 1'b1;
					end else begin
						t_q.hr_o <= c_hr_t ? 4'd0 : t_q.hr_o + 4'd1;
						if (c_hr_t)
							t_q.hr_t <= t_q.hr_t + 4'd1;
					end
				end
			end
		end
	end

	assign value = t_q;

endmodule

>>> src/lever_stopwatch_display_control.sv
// Path: a tick transaction accepted into the input register yields its display
// transaction from the result register, where it waits while the display stalls.
// Throughput: one tick per clock cycle while the display accepts; the output
// register lets a new tick in while a result waits; work is short compare and BCD counting.
// Reset: arst_n clears mode to idle, time and phase counters to zero, registers
// to their defaults and the shown contents to 00:00 with the colon lit.
module lever_stopwatch_display_control #(
	parameter int START_BLINK_HALF_MS = 200,
	parameter int HOLD_BLINK_HALF_MS  = 300,
	parameter int COLON_HALF_MS       = 500,
	parameter int TIME_BITS           = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lsdc_tick_if.sink                      tick,
	lsdc_disp_if.source                    display,
	input  logic                           cfg_we,
	input  logic [lsdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsdc_pkg::CFG_W-1:0]     cfg_wdata
);
	localparam logic [lsdc_pkg::SINCE_W-1:0] SINCE_MAX = '1;

	logic [lsdc_pkg::CFG_W-1:0] start_delay_q, hold_total_q, hold_steady_q;

	logic valid_s1, lever_s1;
	logic out_valid_q;
	logic advance, fire;

	lsdc_pkg::mode_t  mode_q, mode_next;
	logic [TIME_BITS-1:0] tick_q;
	logic [lsdc_pkg::SINCE_W-1:0] since_q;
	logic                 wrap;
	logic                 start_ph, hold_ph, colon_ph;

	lsdc_pkg::elapsed_ctrl_t el_ctrl;
	lsdc_pkg::time_bcd_t     el_value;
	lsdc_pkg::display_t      shown_q, shown_next;
	logic                    since_load, since_step;
	logic                    start_done, hold_done, hold_steady;

	function automatic lsdc_pkg::display_t fmt_time(lsdc_pkg::time_bcd_t t, logic colon);
		lsdc_pkg::display_t d;
		d.colon = colon;
		d.blank = 1'b0;
		if (t.over) begin
			d.d3 = lsdc_pkg::BCD_NINE;
			d.d2 = lsdc_pkg::BCD_NINE;
			d.d1 = lsdc_pkg::BCD_FIVE;
			d.d0 = lsdc_pkg::BCD_NINE;
		end else if (t.hr_t == 4'd0 && t.hr_o == 4'd0) begin
			d.d3 = t.mn_t;
			d.d2 = t.mn_o;
			d.d1 = t.sc_t;
			d.d0 = t.sc_o;
		end else begin
			d.d3 = t.hr_t;
			d.d2 = t.hr_o;
			d.d1 = t.mn_t;
			d.d0 = t.mn_o;
		end
		return d;
	endfunction

	function automatic lsdc_pkg::display_t disp_zero();
		lsdc_pkg::display_t d;
		d = '0;
		d.colon = 1'b1;
		return d;
	endfunction

	function automatic lsdc_pkg::display_t disp_clear();
		lsdc_pkg::display_t d;
		d = '0;
		d.blank = 1'b1;
		return d;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= lsdc_pkg::START_DELAY_RST;
			hold_total_q  <= lsdc_pkg::HOLD_TOTAL_RST;
			hold_steady_q <= lsdc_pkg::HOLD_STEADY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lsdc_pkg::REG_START_DELAY: start_delay_q <= cfg_wdata;
				lsdc_pkg::REG_HOLD_TOTAL:  hold_total_q  <= cfg_wdata;
				lsdc_pkg::REG_HOLD_STEADY: hold_steady_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves when the result register is free or drains
	assign advance    = !out_valid_q || display.ready;
	assign fire       = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready)
			lever_s1 <= tick.lever_down;
	end

	// Count of ticks passed on; its value is "now" for the item in stage one
	assign wrap = &tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (fire) begin
			tick_q <= tick_q + 1'b1;
		end
	end

	lsdc_half_phase #(.HALF_MS(START_BLINK_HALF_MS)) u_start_ph (
		.clk(clk), .arst_n(arst_n), .step(fire), .wrap(wrap), .phase(start_ph)
	);

	lsdc_half_phase #(.HALF_MS(HOLD_BLINK_HALF_MS)) u_hold_ph (
		.clk(clk), .arst_n(arst_n), .step(fire), .wrap(wrap), .phase(hold_ph)
	);

	lsdc_half_phase #(.HALF_MS(COLON_HALF_MS)) u_colon_ph (
		.clk(clk), .arst_n(arst_n), .step(fire), .wrap(wrap), .phase(colon_ph)
	);

	lsdc_elapsed #(.TIME_BITS(TIME_BITS)) u_elapsed (
		.clk(clk), .arst_n(arst_n), .ctrl(el_ctrl), .value(el_value)
	);

	// Phase-end compares against the time since the phase mark
	assign start_done  = since_q > {1'b0, start_delay_q};
	assign hold_done   = since_q > {1'b0, hold_total_q};
	assign hold_steady = since_q < {1'b0, hold_steady_q};

	// Next mode
	always_comb begin
		mode_next = mode_q;
		case (mode_q)
			lsdc_pkg::MODE_IDLE:  if (lever_s1) mode_next = lsdc_pkg::MODE_START;
			lsdc_pkg::MODE_START: if (start_done) mode_next = lsdc_pkg::MODE_RUN;
			lsdc_pkg::MODE_RUN:   if (!lever_s1) mode_next = lsdc_pkg::MODE_HOLD;
			lsdc_pkg::MODE_HOLD:  if (hold_done) mode_next = lsdc_pkg::MODE_IDLE;
			default:              mode_next = lsdc_pkg::MODE_IDLE;
		endcase
	end

	// Display contents and counter controls for this tick
	always_comb begin
		shown_next       = shown_q;
		since_load       = 1'b0;
		since_step       = 1'b0;
		el_ctrl.load_one = 1'b0;
		el_ctrl.advance  = 1'b0;
		case (mode_q)
			lsdc_pkg::MODE_IDLE: begin
				since_load = lever_s1;
			end
			lsdc_pkg::MODE_START: begin
				shown_next       = start_ph ? disp_zero() : disp_clear();
				since_step       = 1'b1;
				el_ctrl.load_one = start_done;
			end
			lsdc_pkg::MODE_RUN: begin
				if (lever_s1) begin
					shown_next      = fmt_time(el_value, colon_ph);
					el_ctrl.advance = 1'b1;
				end else begin
					since_load = 1'b1;
				end
			end
			lsdc_pkg::MODE_HOLD: begin
				since_step = 1'b1;
				if (hold_done)
					shown_next = disp_zero();
				else if (hold_steady || hold_ph)
					shown_next = fmt_time(el_value, colon_ph);
				else
					shown_next = disp_clear();
			end
			default: ;
		endcase
		el_ctrl.load_one = el_ctrl.load_one && fire;
		el_ctrl.advance  = el_ctrl.advance && fire;
	end

	// Mode and since-mark counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsdc_pkg::MODE_IDLE;
			since_q <= '0;
		end else if (fire) begin
			mode_q <= mode_next;
			if (since_load)
				since_q <= lsdc_pkg::SINCE_W'(1);
			else if (since_step && since_q != SINCE_MAX)
				since_q <= since_q + 1'b1;
		end
	end

	// Result register; holds the shown contents between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			shown_q     <= disp_zero();
		end else if (fire) begin
			out_valid_q <= 1'b1;
			shown_q     <= shown_next;
		end else if (display.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign display.valid           = out_valid_q;
	assign display.digit_thousands = shown_q.d3;
	assign display.digit_hundreds  = shown_q.d2;
	assign display.digit_tens      = shown_q.d1;
	assign display.digit_ones      = shown_q.d0;
	assign display.colon_on        = shown_q.colon;
	assign display.blank_display   = shown_q.blank;

endmodule

>>> src/lsdc_checker.sv
// Port-level checks of the display controller, bound to the top level
`include "lever_stopwatch_display_control_macros.svh"

module lsdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       disp_valid,
	input logic       disp_ready,
	input logic [3:0] digit_thousands,
	input logic [3:0] digit_hundreds,
	input logic [3:0] digit_tens,
	input logic [3:0] digit_ones,
	input logic       colon_on,
	input logic       blank_display
);
	// A stalled display transaction stays offered with unchanged contents
	`LSDC_ASSERT_NEXT(a_stall_hold, clk, arst_n, disp_valid && !disp_ready, disp_valid && $stable({digit_thousands, digit_hundreds, digit_tens, digit_ones, colon_on, blank_display}))

	// A cleared display carries zero digits and a dark colon
	`LSDC_ASSERT_IMPLY(a_blank_zero, clk, arst_n, disp_valid && blank_display, digit_thousands == 4'd0 && digit_hundreds == 4'd0 && digit_tens == 4'd0 && digit_ones == 4'd0 && !colon_on)

	// Digits are decimal, and the third digit is a tens of minutes or seconds
	`LSDC_ASSERT_IMPLY(a_digit_range, clk, arst_n, disp_valid, digit_thousands <= 4'd9 && digit_hundreds <= 4'd9 && digit_tens <= 4'd5 && digit_ones <= 4'd9)

endmodule

bind lever_stopwatch_display_control lsdc_checker u_lsdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.disp_valid(display.valid),
	.disp_ready(display.ready),
	.digit_thousands(display.digit_thousands),
	.digit_hundreds(display.digit_hundreds),
	.digit_tens(display.digit_tens),
	.digit_ones(display.digit_ones),
	.colon_on(display.colon_on),
	.blank_display(display.blank_display)
);

>>> tb/sv/tb_lever_stopwatch_display_control.sv
// Testbench for the lever stopwatch display controller: scripted and random ticks, scoreboard
module tb_lever_stopwatch_display_control;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int START_BLINK_MS = 200;
	localparam int HOLD_BLINK_MS  = 300;
	localparam int COLON_MS       = 500;
	localparam int CLOCK_BITS     = 32;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [lsdc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Predicts the display contents of every tick and checks them in order
	class stopwatch_model;
		logic [lsdc_pkg::CFG_W-1:0] start_delay;
		logic [lsdc_pkg::CFG_W-1:0] hold_total;
		logic [lsdc_pkg::CFG_W-1:0] hold_steady;
		lsdc_pkg::mode_t            mode;
		logic [CLOCK_BITS-1:0]      clock_ms;
		logic [CLOCK_BITS-1:0]      mark_ms;
		logic [CLOCK_BITS-1:0]      run_from;
		logic [CLOCK_BITS-1:0]      frozen_ms;
		lsdc_pkg::display_t         shown;
		lsdc_pkg::display_t         pending_displays[$];
		int                         failures;

		function new();
			start_delay = lsdc_pkg::START_DELAY_RST;
			hold_total  = lsdc_pkg::HOLD_TOTAL_RST;
			hold_steady = lsdc_pkg::HOLD_STEADY_RST;
			mode        = lsdc_pkg::MODE_IDLE;
			clock_ms    = '0;
			mark_ms     = '0;
			run_from    = '0;
			frozen_ms   = '0;
			failures    = 0;
			show_zero();
		endfunction

		function void set_register(logic [lsdc_pkg::CFG_IDX_W-1:0] idx,
				logic [lsdc_pkg::CFG_W-1:0] value);
			case (idx)
				lsdc_pkg::REG_START_DELAY: start_delay = value;
				lsdc_pkg::REG_HOLD_TOTAL:  hold_total  = value;
				lsdc_pkg::REG_HOLD_STEADY: hold_steady = value;
				default: ;
			endcase
		endfunction

		// Elapsed run time as the next tick will see it
		function logic [CLOCK_BITS-1:0] elapsed();
			return clock_ms - run_from;
		endfunction

		function bit half_phase(logic [CLOCK_BITS-1:0] now, int unsigned period);
			return bit'((now / period) % 2);
		endfunction

		function void show_zero();
			shown       = '0;
			shown.colon = 1'b1;
		endfunction

		function void show_clear();
			shown       = '0;
			shown.blank = 1'b1;
		endfunction

		function void show_pair(int unsigned hi, int unsigned lo, bit colon);
			shown.d3    = 4'(hi / 10);
			shown.d2    = 4'(hi % 10);
			shown.d1    = 4'(lo / 10);
			shown.d0    = 4'(lo % 10);
			shown.colon = colon;
			shown.blank = 1'b0;
		endfunction

		// MM:SS below one hour, HH:MM above, pinned at 99:59 from 100 hours
		function void show_elapsed(logic [CLOCK_BITS-1:0] ms, logic [CLOCK_BITS-1:0] now);
			int unsigned secs;
			int unsigned hours;
			bit          colon;
			secs  = ms / 1000;
			hours = secs / 3600;
			colon = half_phase(now, COLON_MS);
			if (secs < 3600) begin
				show_pair(secs / 60, secs % 60, colon);
			end else if (hours > 99) begin
				show_pair(99, 59, colon);
			end else begin
				show_pair(hours, (secs % 3600) / 60, colon);
			end
		endfunction

		// Advance one tick and queue the contents it leaves on the display
		function void take_tick(bit lever);
			logic [CLOCK_BITS-1:0] now;
			logic [CLOCK_BITS-1:0] since;
			now      = clock_ms;
			clock_ms = now + 1'b1;
			since    = now - mark_ms;
			case (mode)
				lsdc_pkg::MODE_IDLE: begin
					if (lever) begin
						mark_ms = now;
						mode    = lsdc_pkg::MODE_START;
					end
				end
				lsdc_pkg::MODE_START: begin
					if (half_phase(now, START_BLINK_MS))
						show_zero();
					else
						show_clear();
					if (since > start_delay) begin
						run_from = now;
						mode     = lsdc_pkg::MODE_RUN;
					end
				end
				lsdc_pkg::MODE_RUN: begin
					if (!lever) begin
						frozen_ms = now - run_from;
						mark_ms   = now;
						mode      = lsdc_pkg::MODE_HOLD;
					end else begin
						show_elapsed(now - run_from, now);
					end
				end
				default: begin
					if (since < hold_steady || half_phase(now, HOLD_BLINK_MS))
						show_elapsed(frozen_ms, now);
					else
						show_clear();
					if (since > hold_total) begin
						show_zero();
						mode = lsdc_pkg::MODE_IDLE;
					end
				end
			endcase
			pending_displays.push_back(shown);
		endfunction

		task report_mismatch(string what);
			failures++;
			if (failures <= 40)
				$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task compare_field(string name, logic [3:0] got, logic [3:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task check_display(lsdc_pkg::display_t got);
			lsdc_pkg::display_t want;
			if (pending_displays.size() == 0) begin
				report_mismatch("display transaction with no tick pending");
			end else begin
				want = pending_displays.pop_front();
				compare_field("digit_thousands", got.d3, want.d3);
				compare_field("digit_hundreds", got.d2, want.d2);
				compare_field("digit_tens", got.d1, want.d1);
				compare_field("digit_ones", got.d0, want.d0);
				compare_field("colon_on", 4'(got.colon), 4'(want.colon));
				compare_field("blank_display", 4'(got.blank), 4'(want.blank));
			end
		endtask
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	logic [lsdc_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [lsdc_pkg::CFG_W-1:0]          cfg_wdata;

	lsdc_tick_if tick();
	lsdc_disp_if display();

	stopwatch_model model = new();

	int          gap_pct = 10;
	int          ticks_sent = 0;
	int unsigned goal_lo = 1;
	int unsigned goal_hi = 20;
	int unsigned run_goal = 1;
	bit          lever_script[$];
	logic        stall_display;

	lever_stopwatch_display_control #(
		.START_BLINK_HALF_MS(START_BLINK_MS),
		.HOLD_BLINK_HALF_MS(HOLD_BLINK_MS),
		.COLON_HALF_MS(COLON_MS),
		.TIME_BITS(CLOCK_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.display(display),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Next lever level: scripted first, else shaped by the predicted mode
	function automatic bit pick_lever();
		bit lever;
		if (lever_script.size() != 0)
			return lever_script.pop_front();
		case (model.mode)
			lsdc_pkg::MODE_IDLE: begin
				lever = ($urandom_range(99) < 30);
				if (lever)
					run_goal = $urandom_range(goal_hi, goal_lo);
			end
			lsdc_pkg::MODE_RUN: begin
				lever = (model.elapsed() < run_goal) && ($urandom_range(99) >= 3);
			end
			default: lever = 1'($urandom_range(1));
		endcase
		return lever;
	endfunction

	task automatic send_ticks(int count);
		int accepted = 0;
		while (accepted < count) begin
			@(posedge clk);
			if (tick.valid && tick.ready) begin
				model.take_tick(tick.lever_down);
				accepted++;
				ticks_sent++;
			end
			if (tick.valid && !tick.ready) begin
				// hold the offered transaction
			end else if (accepted == count || $urandom_range(99) < gap_pct) begin
				tick.valid <= 1'b0;
			end else begin
				tick.valid      <= 1'b1;
				tick.lever_down <= pick_lever();
			end
		end
	endtask

	task automatic drain();
		while (model.pending_displays.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [lsdc_pkg::CFG_IDX_W-1:0] idx,
			logic [lsdc_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.set_register(idx, value);
	endtask

	task automatic run_phase(logic [lsdc_pkg::CFG_W-1:0] start,
			logic [lsdc_pkg::CFG_W-1:0] total, logic [lsdc_pkg::CFG_W-1:0] steady,
			int unsigned lo, int unsigned hi, int count, int gaps);
		write_register(lsdc_pkg::REG_START_DELAY, start);
		write_register(lsdc_pkg::REG_HOLD_TOTAL, total);
		write_register(lsdc_pkg::REG_HOLD_STEADY, steady);
		goal_lo = lo;
		goal_hi = hi;
		gap_pct = gaps;
		send_ticks(count);
		drain();
	endtask

	// Accept and check display transactions, stalling at random
	initial begin
		display.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (display.valid && display.ready)
					model.check_display({display.digit_thousands, display.digit_hundreds,
						display.digit_tens, display.digit_ones, display.colon_on,
						display.blank_display});
				display.ready <= !stall_display && ($urandom_range(99) >= gap_pct);
			end
		end
	end

	// Hold off the display side long enough to back up the tick input
	initial begin
		stall_display = 1'b0;
		while (ticks_sent < 120)
			@(posedge clk);
		stall_display <= 1'b1;
		repeat (60) @(posedge clk);
		stall_display <= 1'b0;
	end

	initial begin
		arst_n          = 1'b0;
		tick.valid      = 1'b0;
		tick.lever_down = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = lsdc_pkg::REG_START_DELAY;
		cfg_wdata       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Idle ticks under reset settings show 00:00 with the colon lit
		lever_script = '{0, 0, 0};
		send_ticks(3);
		drain();

		// Short cycle: lever ignored in start blink and hold, blank in hold blink
		write_register(REG_UNUSED, 16'hFFFF);
		write_register(lsdc_pkg::REG_START_DELAY, 16'd3);
		write_register(lsdc_pkg::REG_HOLD_TOTAL, 16'd12);
		write_register(lsdc_pkg::REG_HOLD_STEADY, 16'd5);
		lever_script = '{1, 0, 1, 0, 1, 1, 1, 1, 0,
			1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 0, 1, 1, 0, 0};
		send_ticks(lever_script.size());
		drain();

		// Random cycles under several settings, the extremes among them
		run_phase(16'd5, 16'd20, 16'd8, 1, 30, 150, 10);
		run_phase(16'd0, 16'd0, 16'd0, 1, 10, 100, 10);
		run_phase(16'd2, 16'd15, 16'hFFFF, 1, 25, 100, 0);
		run_phase(16'd40, 16'd250, 16'd100, 20, 150, 300, 10);

		repeat (10) @(posedge clk);
		if (model.failures == 0)
			$display("tb_lever_stopwatch_display_control OK");
		else
			$display("tb_lever_stopwatch_display_control NOT OK");
		$finish;
	end

	// Stop a hung run
	initial begin
		#200us;
		$display("tb_lever_stopwatch_display_control NOT OK");
		$finish;
	end

endmodule
